// ===== hw/rtl/block_group_norm_threshold_top_defines.svh =====
// assertion macros for the block group reduction top level
// needs i_clk and i_rst_n in the scope that uses them
`ifndef BLOCK_GROUP_NORM_THRESHOLD_TOP_DEFINES_SVH
`define BLOCK_GROUP_NORM_THRESHOLD_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define BGNT_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BGNT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BGNT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bgnt_pkg.sv =====
// shared constants, register codes and types of the block group reduction
// no dependencies
`timescale 1ns / 1ps

package bgnt_pkg;

    localparam int VALUE_W   = 32;
    localparam int COEF_W    = 24;
    localparam int MODE_W    = 2;
    localparam int BLEN_W    = 9;
    localparam int SIGMA_W   = 23;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_OUT_W = 6;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam int DEF_MAX_BLOCKS       = 64;
    localparam int DEF_MAX_BLOCK_LENGTH = 256;

    // block reduction codes
    localparam logic [MODE_W-1:0] RG_SUM    = 2'd0;
    localparam logic [MODE_W-1:0] RG_MEAN   = 2'd1;
    localparam logic [MODE_W-1:0] RG_MAXABS = 2'd2;
    localparam logic [MODE_W-1:0] RG_ABSSUM = 2'd3;

    // output rule codes
    localparam logic [MODE_W-1:0] SEL_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] SEL_TENTH = 2'd1;
    localparam logic [MODE_W-1:0] SEL_POS   = 2'd2;
    localparam logic [MODE_W-1:0] SEL_SIGMA = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGROUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA   = 2'd3;

    localparam logic [BLEN_W-1:0] RST_BLEN = 9'd1;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                        done;
        logic signed [VALUE_W-1:0]   quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/bgnt_div.sv =====
// sequential signed-by-unsigned divider, one quotient bit per cycle
// depends on bgnt_pkg
`timescale 1ns / 1ps

module bgnt_div #(
    parameter int DIVISOR_W = $clog2(bgnt_pkg::DEF_MAX_BLOCK_LENGTH + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [bgnt_pkg::VALUE_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]                  i_divisor,
    output bgnt_pkg::t_div_rsp                    o_rsp
);

    localparam int VW    = bgnt_pkg::VALUE_W;
    localparam int CNT_W = $clog2(VW);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [VW-1:0]        r_q;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic                 r_neg;

    logic [DIVISOR_W:0]   shift_rem;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    // restoring step on the magnitude
    always_comb begin
        shift_rem = {r_rem, r_q[VW-1]};
        ge        = shift_rem >= {1'b0, r_div};
        diff      = shift_rem - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend[VW-1] ? VW'(-i_dividend) : VW'(i_dividend);
                r_neg  <= i_dividend[VW-1];
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[VW-2:0], ge};
                r_rem <= ge ? diff[DIVISOR_W-1:0] : shift_rem[DIVISOR_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// ===== hw/rtl/block_group_norm_threshold_top.sv =====
// block group reduction with threshold selection, top level
// depends on bgnt_pkg, bgnt_div and block_group_norm_threshold_top_defines.svh
// a coefficient is accepted in S_IDLE and reduced in S_ACC; closing a block in mean mode
// adds a wait in S_DIV for the bit-serial divider; a final word then emits results via S_RD, S_WR
// s_axis_tready is high only in S_IDLE, so a new coefficient is taken only after the last is reduced
// reset (sync, active low) clears run state and registers; the store needs no clearing pass
`timescale 1ns / 1ps
`include "block_group_norm_threshold_top_defines.svh"

module block_group_norm_threshold_top #(
    parameter int MAX_BLOCKS       = bgnt_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_BLOCK_LENGTH = bgnt_pkg::DEF_MAX_BLOCK_LENGTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [bgnt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bgnt_pkg::CFG_W-1:0]          i_cfg_data,
    // coefficient stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bgnt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [23:0] coefficient
    input  logic                                s_axis_tlast,   // final_item
    // block result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bgnt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [5:0] block_index,
                                                                // [37:6] block_value, [39:38] 0
    output logic                                m_axis_tuser,   // error_flag
    output logic                                m_axis_tlast    // last_result
);

    localparam int VW     = bgnt_pkg::VALUE_W;
    localparam int CW     = bgnt_pkg::COEF_W;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LEN_W  = $clog2(MAX_BLOCK_LENGTH + 1);
    localparam int PAD_W  = bgnt_pkg::OUT_TDATA_W - VW - bgnt_pkg::IDX_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a coefficient
        S_ACC,    // fold the coefficient into the running reduction
        S_DIV,    // mean mode: wait for the block quotient
        S_FIN,    // final word: error check
        S_RD,     // read one stored block value
        S_WR      // select and hand it to the output register
    } t_state;

    // configuration registers
    logic [bgnt_pkg::MODE_W-1:0]   r_regroup;
    logic [bgnt_pkg::MODE_W-1:0]   r_select;
    logic [bgnt_pkg::BLEN_W-1:0]   r_blen;
    logic [bgnt_pkg::SIGMA_W-1:0]  r_sigma;

    // run state
    t_state                r_state, n_state;
    logic signed [CW-1:0]  r_coef;
    logic                  r_final;
    logic signed [VW-1:0]  r_acc, n_acc;
    logic [LEN_W-1:0]      r_pos, n_pos;
    logic [CNT_W-1:0]      r_blocks_done, n_blocks_done;
    logic signed [VW-1:0]  r_largest, n_largest;
    logic                  r_ovf, n_ovf;
    logic [IDX_W-1:0]      r_k, n_k;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [bgnt_pkg::IDX_OUT_W-1:0] r_out_index, n_out_index;
    logic signed [VW-1:0]           r_out_value, n_out_value;
    logic                           r_out_err, n_out_err;
    logic                           r_out_last, n_out_last;

    // block store
    logic signed [VW-1:0]  mem [MAX_BLOCKS];
    logic signed [VW-1:0]  r_rdata;
    logic                  mem_we;
    logic signed [VW-1:0]  mem_wd;
    logic                  rd_en;

    // divider
    logic                  div_start;
    bgnt_pkg::t_div_rsp    div_rsp;

    // datapath
    logic [LEN_W-1:0]      eff_len;
    logic signed [CW:0]    coef_x;
    logic signed [CW:0]    mag;
    logic signed [VW:0]    acc_x;
    logic signed [VW:0]    add_b;
    logic signed [VW:0]    sum;
    logic signed [VW-1:0]  sum_sat;
    logic signed [VW-1:0]  red_val;
    logic [LEN_W-1:0]      pos_inc;
    logic                  store_full;
    logic                  run_err;
    logic                  out_free;
    logic                  emit_last;
    logic signed [VW+3:0]  v36;
    logic signed [VW+3:0]  ten_v;
    logic [bgnt_pkg::SIGMA_W+1:0] three_sigma;
    logic                  sel_bit;
    logic signed [VW-1:0]  sel_val;

    assign s_axis_tready = (r_state == S_IDLE);

    // length clamped to 1..MAX_BLOCK_LENGTH
    always_comb begin
        if (r_blen == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_blen > bgnt_pkg::BLEN_W'(MAX_BLOCK_LENGTH)) begin
            eff_len = LEN_W'(MAX_BLOCK_LENGTH);
        end else begin
            eff_len = LEN_W'(r_blen);
        end
    end

    // running reduction update with saturation
    always_comb begin
        coef_x  = {r_coef[CW-1], r_coef};
        mag     = coef_x[CW] ? -coef_x : coef_x;
        acc_x   = $signed({r_acc[VW-1], r_acc});
        add_b   = (r_regroup == bgnt_pkg::RG_ABSSUM) ? (VW+1)'(mag) : (VW+1)'(coef_x);
        sum     = acc_x + add_b;
        if (sum[VW] != sum[VW-1]) begin
            sum_sat = sum[VW] ? bgnt_pkg::VALUE_MIN : bgnt_pkg::VALUE_MAX;
        end else begin
            sum_sat = sum[VW-1:0];
        end
        if (r_regroup == bgnt_pkg::RG_MAXABS) begin
            red_val = ((VW+1)'(mag) > acc_x) ? VW'(mag) : r_acc;
        end else begin
            red_val = sum_sat;
        end
        pos_inc    = r_pos + LEN_W'(1);
        store_full = (r_blocks_done == CNT_W'(MAX_BLOCKS));
        run_err    = r_ovf || (r_pos != '0) || (r_blocks_done == '0);
        out_free   = !r_out_valid || m_axis_tready;
        emit_last  = ((CNT_W'(r_k) + CNT_W'(1)) == r_blocks_done);
    end

    // selection rule on a stored block value
    always_comb begin
        v36         = (VW+4)'(r_rdata);
        ten_v       = (v36 <<< 3) + (v36 <<< 1);
        three_sigma = (bgnt_pkg::SIGMA_W+2)'(r_sigma) + (bgnt_pkg::SIGMA_W+2)'({r_sigma, 1'b0});
        case (r_select)
            bgnt_pkg::SEL_TENTH: sel_bit = ten_v > (VW+4)'(r_largest);
            bgnt_pkg::SEL_POS:   sel_bit = r_rdata > 0;
            bgnt_pkg::SEL_SIGMA: sel_bit = (VW+2)'(r_rdata) > $signed({7'b0, three_sigma});
            default:             sel_bit = 1'b0;
        endcase
        sel_val = (r_select == bgnt_pkg::SEL_RAW) ? r_rdata : VW'(sel_bit);
    end

    // control and run state next values
    always_comb begin
        n_state       = r_state;
        n_acc         = r_acc;
        n_pos         = r_pos;
        n_blocks_done = r_blocks_done;
        n_largest     = r_largest;
        n_ovf         = r_ovf;
        n_k           = r_k;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_index   = r_out_index;
        n_out_value   = r_out_value;
        n_out_err     = r_out_err;
        n_out_last    = r_out_last;
        mem_we        = 1'b0;
        mem_wd        = red_val;
        rd_en         = 1'b0;
        div_start     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_final ? S_FIN : S_IDLE;
                if (store_full) begin
                    // coefficient dropped
                    n_ovf = 1'b1;
                end else if (pos_inc >= eff_len) begin
                    n_pos = '0;
                    n_acc = '0;
                    if (r_regroup == bgnt_pkg::RG_MEAN) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        mem_we        = 1'b1;
                        n_blocks_done = r_blocks_done + CNT_W'(1);
                        if (red_val > r_largest) begin
                            n_largest = red_val;
                        end
                    end
                end else begin
                    n_pos = pos_inc;
                    n_acc = red_val;
                end
            end
            S_DIV: begin
                mem_wd = div_rsp.quotient;
                if (div_rsp.done) begin
                    mem_we        = 1'b1;
                    n_blocks_done = r_blocks_done + CNT_W'(1);
                    if (div_rsp.quotient > r_largest) begin
                        n_largest = div_rsp.quotient;
                    end
                    n_state = r_final ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (run_err) begin
                    if (out_free) begin
                        n_out_valid   = 1'b1;
                        n_out_index   = '0;
                        n_out_value   = '0;
                        n_out_err     = 1'b1;
                        n_out_last    = 1'b1;
                        n_acc         = '0;
                        n_pos         = '0;
                        n_blocks_done = '0;
                        n_largest     = bgnt_pkg::VALUE_MIN;
                        n_ovf         = 1'b0;
                        n_state       = S_IDLE;
                    end
                end else begin
                    n_k     = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = bgnt_pkg::IDX_OUT_W'(r_k);
                    n_out_value = sel_val;
                    n_out_err   = 1'b0;
                    n_out_last  = emit_last;
                    if (emit_last) begin
                        n_acc         = '0;
                        n_pos         = '0;
                        n_blocks_done = '0;
                        n_largest     = bgnt_pkg::VALUE_MIN;
                        n_ovf         = 1'b0;
                        n_state       = S_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, run registers, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_acc         <= '0;
            r_pos         <= '0;
            r_blocks_done <= '0;
            r_largest     <= bgnt_pkg::VALUE_MIN;
            r_ovf         <= 1'b0;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
            r_regroup     <= bgnt_pkg::RG_SUM;
            r_select      <= bgnt_pkg::SEL_SIGMA;
            r_blen        <= bgnt_pkg::RST_BLEN;
            r_sigma       <= '0;
        end else begin
            r_state       <= n_state;
            r_acc         <= n_acc;
            r_pos         <= n_pos;
            r_blocks_done <= n_blocks_done;
            r_largest     <= n_largest;
            r_ovf         <= n_ovf;
            r_k           <= n_k;
            r_out_valid   <= n_out_valid;
            r_out_index   <= n_out_index;
            r_out_value   <= n_out_value;
            r_out_err     <= n_out_err;
            r_out_last    <= n_out_last;
            if (s_axis_tvalid && s_axis_tready) begin
                r_coef  <= s_axis_tdata[CW-1:0];
                r_final <= s_axis_tlast;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bgnt_pkg::REG_REGROUP: r_regroup <= i_cfg_data[bgnt_pkg::MODE_W-1:0];
                    bgnt_pkg::REG_SELECT:  r_select  <= i_cfg_data[bgnt_pkg::MODE_W-1:0];
                    bgnt_pkg::REG_BLEN:    r_blen    <= i_cfg_data[bgnt_pkg::BLEN_W-1:0];
                    bgnt_pkg::REG_SIGMA:   r_sigma   <= i_cfg_data[bgnt_pkg::SIGMA_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // block store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_blocks_done[IDX_W-1:0]] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= mem[r_k];
        end
    end

    bgnt_div #(
        .DIVISOR_W (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (red_val),
        .i_divisor  (eff_len),
        .o_rsp      (div_rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_value, r_out_index};
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

    // checks
    `BGNT_CHECK(a_cnt_bound, r_blocks_done <= CNT_W'(MAX_BLOCKS), "block count past store depth")
    `BGNT_IMPLIES(a_store_wr, mem_we, !store_full, "block store written while full")
    `BGNT_IMPLIES(a_err_word, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "bad error word")
    `BGNT_NEXT(a_run_clear, (r_state == S_WR) && out_free && emit_last, (r_blocks_done == '0) && !r_ovf, "run not cleared after last result")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for block_group_norm_threshold_top: a directed table, long vectors
// and random vectors, each word checked against values typed in the table or a predictor in this file
// depends on bgnt_pkg and the block_group_norm_threshold_top rtl

module tb_top;
    import bgnt_pkg::*;

    localparam int STORE_DEPTH  = DEF_MAX_BLOCKS;
    localparam int LEN_CAP      = DEF_MAX_BLOCK_LENGTH;
    // drain time for the mean divider plus the accept/reduce pair, rounded up
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int REPORT_LINES = 20;
    localparam int PHASE_ITEMS  = 105;

    localparam logic signed [COEF_W-1:0] COEF_HIGH = 24'sh7F_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_LOW  = 24'sh80_0000;

    typedef enum logic [0:0] { ROW_WRITE, ROW_COEF } row_kind_e;

    // one line of the directed table: either a register write or a coefficient word
    typedef struct packed {
        row_kind_e                 kind;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [CFG_W-1:0]          reg_val;
        logic signed [COEF_W-1:0]  coef;
        logic                      fin;
        logic                      typed;       // single result typed in below
        logic signed [VALUE_W-1:0] want_value;
        logic                      want_err;
    } directed_row_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]      index;
        logic signed [VALUE_W-1:0] value;
        logic                      err;
        logic                      last;
    } block_word_t;

    // ------------------------------------------------------------------
    // clock, reset and dut inputs, all driven to known values from time 0
    // ------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [23:0] coefficient
    logic                   s_axis_tlast  = 1'b0; // final_item
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [5:0] block_index, [37:6] block_value
    logic                   m_axis_tuser;         // error_flag
    logic                   m_axis_tlast;         // last_result

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    block_group_norm_threshold_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // predictor: register copies and run state of the block
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  regroup_cfg = RG_SUM;
    logic [MODE_W-1:0]  select_cfg  = SEL_SIGMA;
    logic [BLEN_W-1:0]  blen_cfg    = RST_BLEN;
    logic [SIGMA_W-1:0] sigma_cfg   = '0;

    int     block_values [STORE_DEPTH];
    longint partial_value  = 0;
    int     fill_count     = 0;
    int     stored_blocks  = 0;
    longint peak_value     = longint'(VALUE_MIN);
    bit     store_overflow = 1'b0;

    block_word_t fresh_words[$];       // words caused by the latest coefficient
    block_word_t expected_blocks[$];   // words still owed by the dut

    int          mismatch_count = 0;
    int          words_seen     = 0;
    int          error_words    = 0;
    int          coefs_sent     = 0;
    int          random_items   = 0;
    int          cycle_count    = 0;
    int unsigned send_idle_pct  = 37;
    int unsigned recv_idle_pct  = 49;
    logic        hold_request   = 1'b0;
    int          hold_left      = 0;

    function automatic longint clamp_q16(input longint v);
        if (v > longint'(VALUE_MAX)) return longint'(VALUE_MAX);
        if (v < longint'(VALUE_MIN)) return longint'(VALUE_MIN);
        return v;
    endfunction

    // fold one coefficient into the run; on the final word, list what comes out
    function automatic void reduce_coefficient(input logic signed [COEF_W-1:0] coef,
                                               input logic fin);
        longint c, mag, v;
        int     len, k;
        fresh_words.delete();
        // zero length behaves as one, anything past the length cap is capped
        len = (blen_cfg == 0) ? 1 : ((blen_cfg > LEN_CAP) ? LEN_CAP : int'(blen_cfg));
        c   = coef;
        mag = (c < 0) ? -c : c;
        if (stored_blocks >= STORE_DEPTH) begin
            // store full, word dropped
            store_overflow = 1'b1;
        end else begin
            case (regroup_cfg)
                RG_MAXABS: if (mag > partial_value) partial_value = mag;
                RG_ABSSUM: partial_value = clamp_q16(partial_value + mag);
                default:   partial_value = clamp_q16(partial_value + c);
            endcase
            fill_count++;
            // reaching or passing the length closes the block, even after a shrink
            if (fill_count >= len) begin
                v = partial_value;
                if (regroup_cfg == RG_MEAN) v = v / len;
                block_values[stored_blocks] = int'(v);
                if (v > peak_value) peak_value = v;
                stored_blocks++;
                partial_value = 0;
                fill_count    = 0;
            end
        end
        if (!fin) return;

        if (store_overflow || fill_count != 0 || stored_blocks == 0) begin
            fresh_words.push_back('{index: '0, value: '0, err: 1'b1, last: 1'b1});
        end else begin
            for (k = 0; k < stored_blocks; k++) begin
                v = block_values[k];
                case (select_cfg)
                    SEL_TENTH: v = (10 * v > peak_value) ? 1 : 0;
                    SEL_POS:   v = (v > 0) ? 1 : 0;
                    SEL_SIGMA: v = (v > 3 * longint'(sigma_cfg)) ? 1 : 0;
                    default:   ;
                endcase
                fresh_words.push_back('{index: k[IDX_OUT_W-1:0], value: v[VALUE_W-1:0],
                                        err: 1'b0, last: (k == stored_blocks - 1)});
            end
        end
        partial_value  = 0;
        fill_count     = 0;
        stored_blocks  = 0;
        peak_value     = longint'(VALUE_MIN);
        store_overflow = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("word %0d: %s is %0d, should be %0d", words_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // offer one coefficient word, at times after a random gap; predicts at the accepting edge
    task automatic send_item(input logic signed [COEF_W-1:0] coef, input logic fin,
                             input bit keep);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= coef;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        reduce_coefficient(coef, fin);
        coefs_sent++;
        if (keep)
            foreach (fresh_words[i]) expected_blocks.push_back(fresh_words[i]);
    endtask

    // stop offering, wait for every owed word, then let the divider and emitter finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_REGROUP: regroup_cfg = val[MODE_W-1:0];
            REG_SELECT:  select_cfg  = val[MODE_W-1:0];
            REG_BLEN:    blen_cfg    = val[BLEN_W-1:0];
            REG_SIGMA:   sigma_cfg   = val[SIGMA_W-1:0];
            default:     ;
        endcase
    endtask

    // full range, small values near zero, the extremes, and mid-size values
    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic signed [COEF_W-1:0] c;
        c = COEF_W'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: c = c >>> $urandom_range(12, 23);
            2: begin
                case ($urandom_range(0, 3))
                    0:       c = COEF_HIGH;
                    1:       c = COEF_LOW;
                    2:       c = '0;
                    default: c = -1;
                endcase
            end
            default: c = c >>> $urandom_range(1, 11);
        endcase
        return c;
    endfunction

    task automatic write_random_config();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        write_reg(REG_REGROUP, CFG_W'($urandom_range(RG_SUM, RG_ABSSUM)));
        write_reg(REG_SELECT, CFG_W'($urandom_range(SEL_RAW, SEL_SIGMA)));
        write_reg(REG_BLEN, (pick == 0) ? '0 : CFG_W'($urandom_range(1, (pick < 3) ? 12 : 5)));
        write_reg(REG_SIGMA, CFG_W'($urandom_range(0, 23'h7F_FFFF) >> $urandom_range(0, 22)));
    endtask

    // mostly whole vectors of random blocks; some one word off, some loose noise
    task automatic run_random_vector();
        int unsigned shape;
        int          len_eff, total, rewrite_at, n;
        bit          noise;
        logic        fin;
        settle();
        write_random_config();
        len_eff = (blen_cfg == 0) ? 1 : int'(blen_cfg);
        total   = len_eff * $urandom_range(1, 8);
        shape   = $urandom_range(0, 9);
        noise   = (shape >= 8);
        if (shape == 7)
            total = (total > 1 && $urandom_range(0, 1) == 1) ? total - 1 : total + 1;
        if (noise)
            total = $urandom_range(1, 6);
        rewrite_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : -1;
        for (n = 0; n < total; n++) begin
            // register change in the middle of a vector, once the block has gone quiet
            if (n == rewrite_at) begin
                settle();
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_REGROUP, CFG_W'($urandom_range(RG_SUM, RG_ABSSUM)));
                else
                    write_reg(REG_BLEN, CFG_W'($urandom_range(1, 5)));
            end
            fin = noise ? ($urandom_range(0, 3) == 0) : (n == total - 1);
            send_item(rand_coef(), fin, 1'b1);
            random_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // directed table: extremes, each mode, and the special cases
    // ------------------------------------------------------------------
    localparam int DIRECTED_ROWS = 41;
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_WRITE, REG_SELECT,  SEL_RAW,   '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        COEF_HIGH, 1'b1, 1'b1, 8388607,   1'b0},
        '{ROW_COEF,  '0,          '0,        COEF_LOW,  1'b1, 1'b1, -8388608,  1'b0},
        // one word against a length of two: not a whole block
        '{ROW_WRITE, REG_BLEN,    2,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        5,         1'b1, 1'b1, 0,         1'b1},
        // zero length acts as one
        '{ROW_WRITE, REG_BLEN,    0,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        3,         1'b1, 1'b1, 3,         1'b0},
        // mean truncates toward zero
        '{ROW_WRITE, REG_REGROUP, RG_MEAN,   '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_WRITE, REG_BLEN,    2,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        -3,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        0,         1'b1, 1'b1, -1,        1'b0},
        '{ROW_COEF,  '0,          '0,        7,         1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        8,         1'b1, 1'b1, 7,         1'b0},
        '{ROW_WRITE, REG_REGROUP, RG_MAXABS, '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        -7,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        5,         1'b1, 1'b1, 7,         1'b0},
        '{ROW_WRITE, REG_REGROUP, RG_ABSSUM, '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        -7,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        5,         1'b1, 1'b1, 12,        1'b0},
        // three words into a block of four, then the length drops to two
        '{ROW_WRITE, REG_REGROUP, RG_SUM,    '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_WRITE, REG_BLEN,    4,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        1,         1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        2,         1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        3,         1'b0, 1'b0, '0,        1'b0},
        '{ROW_WRITE, REG_BLEN,    2,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        4,         1'b1, 1'b1, 10,        1'b0},
        '{ROW_WRITE, REG_SELECT,  SEL_POS,   '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_WRITE, REG_BLEN,    1,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        0,         1'b1, 1'b1, 0,         1'b0},
        '{ROW_COEF,  '0,          '0,        1,         1'b1, 1'b1, 1,         1'b0},
        '{ROW_COEF,  '0,          '0,        -1,        1'b1, 1'b1, 0,         1'b0},
        // three sigma threshold is strict
        '{ROW_WRITE, REG_SELECT,  SEL_SIGMA, '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_WRITE, REG_SIGMA,   1,         '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        3,         1'b1, 1'b1, 0,         1'b0},
        '{ROW_COEF,  '0,          '0,        4,         1'b1, 1'b1, 1,         1'b0},
        '{ROW_WRITE, REG_SIGMA,   23'h7F_FFFF, '0,      1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        COEF_HIGH, 1'b1, 1'b1, 0,         1'b0},
        // tenth of the largest block, three blocks
        '{ROW_WRITE, REG_SELECT,  SEL_TENTH, '0,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        10,        1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        1,         1'b0, 1'b0, '0,        1'b0},
        '{ROW_COEF,  '0,          '0,        -5,        1'b1, 1'b0, '0,        1'b0}
    };

    // ------------------------------------------------------------------
    // result side: ready with random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each accepted word with the oldest one owed
    always @(posedge i_clk) begin
        block_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (m_axis_tuser) error_words++;
            if (expected_blocks.size() == 0) begin
                report_mismatch("word with nothing owed, block_value",
                                $signed(m_axis_tdata[37:6]), 0);
            end else begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata[5:0] !== want.index)
                    report_mismatch("block_index", m_axis_tdata[5:0], want.index);
                if (m_axis_tdata[37:6] !== want.value)
                    report_mismatch("block_value", $signed(m_axis_tdata[37:6]), want.value);
                if (m_axis_tuser !== want.err)
                    report_mismatch("error_flag", m_axis_tuser, want.err);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_result", m_axis_tlast, want.last);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still owed",
                 cycle_count, expected_blocks.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        directed_row_t row;
        int            phase, n;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.coef, row.fin, !row.typed);
                if (row.typed)
                    expected_blocks.push_back('{index: '0, value: row.want_value,
                                                err: row.want_err, last: 1'b1});
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 37; recv_idle_pct = 49; end
                1:       begin send_idle_pct = 49; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            if (phase == 0) begin
                // a length past the cap behaves as 256, so two words are a broken block
                settle();
                write_reg(REG_REGROUP, RG_ABSSUM);
                write_reg(REG_SELECT, SEL_RAW);
                write_reg(REG_BLEN, CFG_W'(9'h1FF));
                send_item(rand_coef(), 1'b0, 1'b1);
                send_item(rand_coef(), 1'b1, 1'b1);
                // one block of 256 most negative words: the absolute sum saturates
                settle();
                write_reg(REG_BLEN, CFG_W'(LEN_CAP));
                for (n = 0; n < LEN_CAP; n++)
                    send_item(COEF_LOW, n == LEN_CAP - 1, 1'b1);
            end

            if (phase == 2) begin
                // full store answered with 64 words while the receiver holds off,
                // then one word too many for the store on the next vector
                settle();
                write_reg(REG_REGROUP, RG_SUM);
                write_reg(REG_SELECT, SEL_TENTH);
                write_reg(REG_BLEN, 1);
                hold_request <= 1'b1;
                for (n = 0; n < STORE_DEPTH; n++)
                    send_item(rand_coef(), n == STORE_DEPTH - 1, 1'b1);
                for (n = 0; n <= STORE_DEPTH; n++)
                    send_item(rand_coef(), n == STORE_DEPTH, 1'b1);
            end

            while (random_items < (phase + 1) * PHASE_ITEMS)
                run_random_vector();
        end

        settle();
        $display("%0d coefficient words in, %0d block words out (%0d with the error flag), %0d cycles",
                 coefs_sent, words_seen, error_words, cycle_count);
        $display("all reductions and output rules, a saturated block, a full store, long stall");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
